FILE: rtl/core/skt_pkg.sv
package skt_pkg;

	// Field widths of one record, one result word and the operation code.
	localparam int KEY_W    = 16;
	localparam int YEAR_W   = 14;
	localparam int TAG_W    = 16;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LIST   = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	// One stored record.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [YEAR_W-1:0] year;
		logic [TAG_W-1:0]  tag;
	} rec_t;

	// One result word.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    key;
		logic [YEAR_W-1:0]   year;
		logic [TAG_W-1:0]    tag;
		logic                last;
	} rslt_t;

endpackage

FILE: rtl/core/skt_ram.sv
module skt_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output skt_pkg::rec_t   rdata,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  skt_pkg::rec_t   wdata
);
	import skt_pkg::*;

	rec_t mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Single read port, data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/skt_outq.sv
module skt_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  skt_pkg::rslt_t       push_data,
	output logic [skt_pkg::QCW-1:0] occ,
	output logic                 valid,
	input  logic                 ready,
	output skt_pkg::rslt_t       head
);
	import skt_pkg::*;

	rslt_t            slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   occ_q;
	logic             pop;

	assign valid = (occ_q != '0);
	assign pop   = valid && ready;
	assign head  = slot_q[rd_ptr_q];
	assign occ   = occ_q;

	// Storage for queued words.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			occ_q <= occ_q + QCW'(push) - QCW'(pop);
		end
	end

endmodule

FILE: rtl/core/skt_ctrl.sv
module skt_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [skt_pkg::OP_W-1:0]    op,
	input  logic [skt_pkg::KEY_W-1:0]   shelf_key,
	input  logic [skt_pkg::YEAR_W-1:0]  pub_year,
	input  logic [skt_pkg::TAG_W-1:0]   record_tag,
	output logic                        re,
	output logic [AW-1:0]               raddr,
	input  skt_pkg::rec_t               rdata,
	output logic                        we,
	output logic [AW-1:0]               waddr,
	output skt_pkg::rec_t               wdata,
	input  logic [skt_pkg::QCW-1:0]     q_occ,
	output logic                        push,
	output skt_pkg::rslt_t              push_data
);
	import skt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_INS   = 6'b000010,
		S_PLACE = 6'b000100,
		S_DEL   = 6'b001000,
		S_LIST  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q, count_d, count_m1;
	logic [AW-1:0]         idx_q, idx_d, last_idx;
	logic                  more_q, more_d;
	logic                  found_q, found_d;
	logic [STATUS_W-1:0]   status_q, status_d;
	logic                  rd_vld_s1, rd_last_s1, rd_last;
	logic [AW-1:0]         rd_idx_s1;
	logic [KEY_W-1:0]      key_q;
	logic [YEAR_W-1:0]     year_q;
	logic [TAG_W-1:0]      tag_q;
	logic                  accept, full, empty, q_room;
	rec_t                  new_rec;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign count_m1   = count_q - CW'(1);
	assign last_idx   = count_m1[AW-1:0];
	assign full       = (count_q == CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign new_rec    = '{key: key_q, year: year_q, tag: tag_q};

	// A list read is issued only when the result queue has a slot reserved for it.
	assign q_room = ((4'(q_occ) + 4'(rd_vld_s1)) < 4'(QDEPTH));

	// Read issue: insert walks down from the tail, delete and list walk up from the head.
	assign re = more_q && ((state_q == S_INS) || (state_q == S_DEL) ||
		((state_q == S_LIST) && q_room));
	assign raddr   = idx_q;
	assign rd_last = (state_q == S_INS) ? (idx_q == '0) : (idx_q == last_idx);

	// Sequencer: next state, memory write port and result push.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		more_d    = more_q;
		found_d   = found_q;
		status_d  = status_q;
		we        = 1'b0;
		waddr     = rd_idx_s1;
		wdata     = rdata;
		push      = 1'b0;
		push_data = '{status: status_q, key: '0, year: '0, tag: '0, last: 1'b1};

		if (re) begin
			if (rd_last) begin
				more_d = 1'b0;
			end else if (state_q == S_INS) begin
				idx_d = idx_q - AW'(1);
			end else begin
				idx_d = idx_q + AW'(1);
			end
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_INSERT: begin
							if (full) begin
								status_d = ST_FULL;
								state_d  = S_RESP;
							end else if (empty) begin
								we       = 1'b1;
								waddr    = '0;
								wdata    = '{key: shelf_key, year: pub_year, tag: record_tag};
								count_d  = count_q + CW'(1);
								status_d = ST_OK;
								state_d  = S_RESP;
							end else begin
								idx_d   = last_idx;
								more_d  = 1'b1;
								state_d = S_INS;
							end
						end
						OP_LIST: begin
							if (empty) begin
								status_d = ST_EMPTY;
								state_d  = S_RESP;
							end else begin
								idx_d   = '0;
								more_d  = 1'b1;
								state_d = S_LIST;
							end
						end
						OP_DELETE: begin
							if (empty) begin
								status_d = ST_EMPTY;
								state_d  = S_RESP;
							end else begin
								idx_d   = '0;
								more_d  = 1'b1;
								found_d = 1'b0;
								state_d = S_DEL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				// Records with a key not below the new one move up one place.
				if (rd_vld_s1) begin
					we    = 1'b1;
					waddr = rd_idx_s1 + AW'(1);
					if (rdata.key >= key_q) begin
						wdata = rdata;
						if (rd_idx_s1 == '0) begin
							state_d = S_PLACE;
						end
					end else begin
						wdata    = new_rec;
						count_d  = count_q + CW'(1);
						status_d = ST_OK;
						more_d   = 1'b0;
						state_d  = S_RESP;
					end
				end
			end
			S_PLACE: begin
				// Every record moved, so the new one goes to the head.
				we       = 1'b1;
				waddr    = '0;
				wdata    = new_rec;
				count_d  = count_q + CW'(1);
				status_d = ST_OK;
				state_d  = S_RESP;
			end
			S_DEL: begin
				// After the first match, each later record moves down one place.
				if (rd_vld_s1) begin
					if (found_q) begin
						we    = 1'b1;
						waddr = rd_idx_s1 - AW'(1);
						wdata = rdata;
					end else if (rdata.key == key_q) begin
						found_d = 1'b1;
					end
					if (rd_last_s1) begin
						if (found_d) begin
							count_d  = count_q - CW'(1);
							status_d = ST_OK;
						end else begin
							status_d = ST_NOT_FOUND;
						end
						state_d = S_RESP;
					end
				end
			end
			S_LIST: begin
				if (rd_vld_s1) begin
					push      = 1'b1;
					push_data = '{status: ST_OK, key: rdata.key, year: rdata.year,
						tag: rdata.tag, last: rd_last_s1};
					if (rd_last_s1) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				if (q_occ < QCW'(QDEPTH)) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			more_q     <= 1'b0;
			found_q    <= 1'b0;
			status_q   <= ST_OK;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			idx_q      <= idx_d;
			more_q     <= more_d;
			found_q    <= found_d;
			status_q   <= status_d;
			rd_vld_s1  <= re;
			rd_last_s1 <= rd_last;
			rd_idx_s1  <= idx_q;
		end
	end

	// Operands of the accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= shelf_key;
			year_q <= pub_year;
			tag_q  <= record_tag;
		end
	end

	// The shifting walks never read and write the same entry in one cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(re && we && (raddr == waddr)))
		else $error("read and write hit the same entry");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count exceeds depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_occ < QCW'(QDEPTH)))
		else $error("result pushed into a full queue");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_INSERT) && full) |=>
		((state_q == S_RESP) && (status_q == ST_FULL) && $stable(count_q)))
		else $error("insert into full table not rejected");

endmodule

FILE: rtl/core/sorted_keyed_table.sv
// Sorted record table: holds up to DEPTH records (shelf key, year, tag) in
// ascending key order in a single-port-read, single-port-write memory, and
// handles one word at a time. An insert walks down from the tail until it
// meets a record below the new key, a delete walks all stored records, and
// a list streams one record per cycle when the result side keeps up; each
// walk reads the record memory one entry per cycle through its one read port.
// Results pass through a four-word queue, so a new word is taken while
// earlier results still wait. Word code three is taken and dropped without a
// result. No clearing pass runs after reset.
module sorted_keyed_table #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [skt_pkg::OP_W-1:0]    op,
	input  logic [skt_pkg::KEY_W-1:0]   shelf_key,
	input  logic [skt_pkg::YEAR_W-1:0]  pub_year,
	input  logic [skt_pkg::TAG_W-1:0]   record_tag,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [skt_pkg::STATUS_W-1:0] status,
	output logic [skt_pkg::KEY_W-1:0]   out_key,
	output logic [skt_pkg::YEAR_W-1:0]  out_year,
	output logic [skt_pkg::TAG_W-1:0]   out_tag,
	output logic                        last
);
	import skt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic            re, we, push;
	logic [AW-1:0]   raddr, waddr;
	rec_t            rdata, wdata;
	logic [QCW-1:0]  q_occ;
	rslt_t           push_data, head;

	// Sequencer.
	skt_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.op         (op),
		.shelf_key  (shelf_key),
		.pub_year   (pub_year),
		.record_tag (record_tag),
		.re         (re),
		.raddr      (raddr),
		.rdata      (rdata),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata),
		.q_occ      (q_occ),
		.push       (push),
		.push_data  (push_data)
	);

	// Record memory.
	skt_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata)
	);

	// Result queue.
	skt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.occ       (q_occ),
		.valid     (result_valid),
		.ready     (result_ready),
		.head      (head)
	);

	// Result word fields.
	assign status   = head.status;
	assign out_key  = head.key;
	assign out_year = head.year;
	assign out_tag  = head.tag;
	assign last     = head.last;

endmodule
